@@ design/jts_pkg.sv @@
// types and constants shared by the token splitter modules
package jts_pkg;

   localparam logic [7:0] BYTE_LBRACE    = 8'h7B;
   localparam logic [7:0] BYTE_RBRACE    = 8'h7D;
   localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
   localparam logic [7:0] BYTE_RBRACKET  = 8'h5D;
   localparam logic [7:0] BYTE_COLON     = 8'h3A;
   localparam logic [7:0] BYTE_COMMA     = 8'h2C;
   localparam logic [7:0] BYTE_QUOTE     = 8'h22;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] BYTE_LF        = 8'h0A;
   localparam logic [7:0] BYTE_CR        = 8'h0D;
   localparam logic [7:0] BYTE_BOM_EF    = 8'hEF;
   localparam logic [7:0] BYTE_BOM_BB    = 8'hBB;
   localparam logic [7:0] BYTE_BOM_BF    = 8'hBF;

   // output queue: room for two words per item plus slack for a stalled sink
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = 2;
   localparam int COUNT_W     = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] held_byte;
      logic       held_valid;
      logic       inside_string;
      logic       after_backslash;
   } state_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    word0;
      rsp_type    word1;
   } step_type;

endpackage

@@ design/jts_classify.sv @@
// byte classification and token state update for one input word
module jts_classify (
   input  jts_pkg::req_type   item,
   input  jts_pkg::state_type state,
   output jts_pkg::state_type state_next,
   output jts_pkg::step_type  step
);

   logic [7:0] b;
   logic       structural;
   logic       dropped;

   assign b = item.data_byte;

   assign structural = (b == jts_pkg::BYTE_LBRACE) || (b == jts_pkg::BYTE_RBRACE) ||
                       (b == jts_pkg::BYTE_LBRACKET) || (b == jts_pkg::BYTE_RBRACKET) ||
                       (b == jts_pkg::BYTE_COLON) || (b == jts_pkg::BYTE_COMMA);

   assign dropped = (b == jts_pkg::BYTE_SPACE) || (b == jts_pkg::BYTE_TAB) ||
                    (b == jts_pkg::BYTE_LF) || (b == jts_pkg::BYTE_CR) ||
                    (b == jts_pkg::BYTE_BOM_EF) || (b == jts_pkg::BYTE_BOM_BB) ||
                    (b == jts_pkg::BYTE_BOM_BF);

   always_comb begin
      state_next = state;
      step.num   = 2'd0;
      step.word0 = '{token_byte: state.held_byte, token_end: 1'b0, run_last: 1'b1};
      step.word1 = '{token_byte: b, token_end: 1'b1, run_last: 1'b1};

      if (item.end_of_stream) begin
         step.num             = {1'b0, state.held_valid};
         step.word0.token_end = 1'b1;
         state_next           = '0;
      end else if (state.after_backslash || state.inside_string ||
                   !(structural || dropped)) begin
         // append: previous held byte leaves without ending its token
         step.num             = {1'b0, state.held_valid};
         state_next.held_byte  = b;
         state_next.held_valid = 1'b1;
         if (state.after_backslash) begin
            state_next.after_backslash = 1'b0;
         end else if (state.inside_string) begin
            if (b == jts_pkg::BYTE_QUOTE) begin
               state_next.inside_string = 1'b0;
            end else if (b == jts_pkg::BYTE_BACKSLASH) begin
               state_next.after_backslash = 1'b1;
            end
         end else if (b == jts_pkg::BYTE_QUOTE || b == jts_pkg::BYTE_BACKSLASH) begin
            state_next.inside_string = 1'b1;
         end
      end else begin
         // boundary byte outside a string
         step.word0.token_end  = 1'b1;
         step.word0.run_last   = !structural;
         state_next.held_valid = 1'b0;
         state_next.held_byte  = 8'h00;
         if (state.held_valid) begin
            step.num = structural ? 2'd2 : 2'd1;
         end else if (structural) begin
            step.num   = 2'd1;
            step.word0 = step.word1;
         end
      end
   end

endmodule

@@ design/jts_queue.sv @@
// small output queue taking up to two words per cycle and giving one unless rsp_stall is high
module jts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_num,
   input  jts_pkg::rsp_type push_word0,
   input  jts_pkg::rsp_type push_word1,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jts_pkg::rsp_type rsp_data
);

   jts_pkg::rsp_type entry_ff [jts_pkg::QUEUE_DEPTH];

   logic [jts_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [jts_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [jts_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [jts_pkg::PTR_W-1:0]   wr_ptr_next;
   logic                        pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // two free entries before any pop this cycle
   assign room        = (count_ff <= jts_pkg::COUNT_W'(jts_pkg::QUEUE_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + jts_pkg::PTR_W'(1);

   assign rd_ptr_in = rd_ptr_ff + jts_pkg::PTR_W'(pop);
   assign wr_ptr_in = wr_ptr_ff + jts_pkg::PTR_W'(push_num);
   assign count_in  = count_ff + jts_pkg::COUNT_W'(push_num) - jts_pkg::COUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_word1;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_num != 2'd0) |-> room)
      else $error("queue push without room");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push_num == 2'd0) |=> (count_ff == '0))
      else $error("queue count moved with no push");
`endif

endmodule

@@ design/json_token_splitter.sv @@
// top level of the JSON token splitter
//
//  port group   dir  handshake               word
//  req_         in   req_valid / req_stall   jts_pkg::req_type (byte, end of stream)
//  rsp_         out  rsp_valid / rsp_stall   jts_pkg::rsp_type (byte, end, run last)
//
// an input word passes the input register, is classified combinationally and
// lands in a four-entry output queue; one word per cycle is accepted while req_stall is low
// a word that yields two results (held byte plus a structural byte) sends them
// out one after the other through the single output port of the queue
// reset is synchronous and clears the input valid flag, token state and queue
// req_stall rises only while the queue lacks room for two more words
module json_token_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jts_pkg::rsp_type rsp_data
);

   jts_pkg::req_type   in_ff, in_in;
   logic               in_valid_ff, in_valid_in;
   jts_pkg::state_type state_ff, state_in;
   jts_pkg::state_type state_next;
   jts_pkg::step_type  step;
   logic               room;
   logic               process;
   logic               accept;
   logic [1:0]         push_num;

   assign process   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign push_num  = process ? step.num : 2'd0;

   assign in_in       = accept ? req_data : in_ff;
   assign in_valid_in = accept || (in_valid_ff && !process);
   assign state_in    = process ? state_next : state_ff;

   jts_classify u_classify (
      .item       (in_ff),
      .state      (state_ff),
      .state_next (state_next),
      .step       (step)
   );

   jts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_num   (push_num),
      .push_word0 (step.word0),
      .push_word1 (step.word1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

`ifndef ASSERT_OFF
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (process && in_ff.end_of_stream) |=> (state_ff == '0))
      else $error("end of stream left token state behind");

   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      state_ff.after_backslash |-> state_ff.inside_string)
      else $error("escape pending outside a string");
`endif

endmodule

@@ tb/json_token_splitter_tb.sv @@
// testbench for the json token splitter: directed and random byte streams checked word by word
`timescale 1ns / 1ps

module json_token_splitter_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int ITEM_TARGET = 1850;

   typedef struct {
      jts_pkg::req_type word;
      int               gap;
   } queued_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   jts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   jts_pkg::rsp_type rsp_data;

   queued_word_type  words_to_send[$];
   queued_word_type  staged_word;
   bit               staged = 1'b0;
   jts_pkg::rsp_type tokens_due[$];
   jts_pkg::rsp_type due_word;

   // token state as the splitter should hold it
   logic [7:0] held_q = '0;
   logic       held_v = 1'b0;
   logic       in_str = 1'b0;
   logic       escaping = 1'b0;

   bit tx_calm = 1'b1, rx_calm = 1'b1, hold_request = 1'b0, pressure_done = 1'b0;
   int stall_left = 0, hold_left = 0, quiet_cycles = 0;
   int items_sent = 0, marks_sent = 0, words_checked = 0, error_count = 0;

   json_token_splitter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit is_structural(logic [7:0] b);
      return b inside {jts_pkg::BYTE_LBRACE, jts_pkg::BYTE_RBRACE, jts_pkg::BYTE_LBRACKET,
                       jts_pkg::BYTE_RBRACKET, jts_pkg::BYTE_COLON, jts_pkg::BYTE_COMMA};
   endfunction

   // the byte held so far leaves as a middle byte, the new one is held
   task automatic append_held(input logic [7:0] b, ref jts_pkg::rsp_type produced[$]);
      if (held_v)
         produced.push_back(jts_pkg::rsp_type'{token_byte: held_q, token_end: 1'b0,
                                               run_last: 1'b0});
      held_q = b;
      held_v = 1'b1;
   endtask

   task automatic split_step(input jts_pkg::req_type w);
      jts_pkg::rsp_type produced[$];
      logic [7:0]       b;
      b = w.data_byte;
      if (w.end_of_stream) begin
         if (held_v)
            produced.push_back(jts_pkg::rsp_type'{token_byte: held_q, token_end: 1'b1,
                                                  run_last: 1'b0});
         held_q = '0;
         held_v = 1'b0;
         in_str = 1'b0;
         escaping = 1'b0;
      end else if (escaping) begin
         escaping = 1'b0;
         append_held(b, produced);
      end else if (in_str) begin
         if (b == jts_pkg::BYTE_QUOTE)
            in_str = 1'b0;
         else if (b == jts_pkg::BYTE_BACKSLASH)
            escaping = 1'b1;
         append_held(b, produced);
      end else if (is_structural(b) || b inside {jts_pkg::BYTE_SPACE, jts_pkg::BYTE_TAB,
                                                 jts_pkg::BYTE_LF, jts_pkg::BYTE_CR,
                                                 jts_pkg::BYTE_BOM_EF, jts_pkg::BYTE_BOM_BB,
                                                 jts_pkg::BYTE_BOM_BF}) begin
         if (held_v) begin
            produced.push_back(jts_pkg::rsp_type'{token_byte: held_q, token_end: 1'b1,
                                                  run_last: 1'b0});
            held_v = 1'b0;
            held_q = '0;
         end
         if (is_structural(b))
            produced.push_back(jts_pkg::rsp_type'{token_byte: b, token_end: 1'b1,
                                                  run_last: 1'b0});
      end else begin
         // a backslash outside a string opens one like a quote, with no escape
         if (b == jts_pkg::BYTE_QUOTE || b == jts_pkg::BYTE_BACKSLASH)
            in_str = 1'b1;
         append_held(b, produced);
      end
      if (produced.size() > 0)
         produced[produced.size() - 1].run_last = 1'b1;
      foreach (produced[i])
         tokens_due.push_back(produced[i]);
   endtask

   // driver: gap cycles with valid low come before each word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            split_step(req_data);
         if (!(req_valid && req_stall)) begin
            if (!staged && words_to_send.size() > 0) begin
               staged_word = words_to_send.pop_front();
               staged = 1'b1;
            end
            if (staged && staged_word.gap == 0) begin
               req_valid <= 1'b1;
               req_data <= staged_word.word;
               staged = 1'b0;
            end else begin
               req_valid <= 1'b0;
               if (staged)
                  staged_word.gap--;
            end
         end
      end
   end

   // monitor: checks each token word and draws the stall before the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (tokens_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected token word: got byte %h end %b last %b", $time,
                        rsp_data.token_byte, rsp_data.token_end, rsp_data.run_last);
            end else begin
               due_word = tokens_due.pop_front();
               if (rsp_data !== due_word) begin
                  error_count++;
                  $display("%0t: token mismatch: expected %h/%b/%b, got %h/%b/%b",
                           $time, due_word.token_byte, due_word.token_end, due_word.run_last,
                           rsp_data.token_byte, rsp_data.token_end, rsp_data.run_last);
               end
            end
            stall_left = rx_calm ? 0 : $urandom_range(0, 11);
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d token words still due", $time,
                  quiet_cycles, tokens_due.size());
         $display("json_token_splitter_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eos);
      queued_word_type q;
      q.word.data_byte = b;
      q.word.end_of_stream = eos;
      q.gap = tx_calm ? 0 : int'($urandom_range(0, 11));
      words_to_send.push_back(q);
      items_sent++;
      if (eos)
         marks_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_structural();
      case ($urandom_range(0, 5))
         0: return jts_pkg::BYTE_LBRACE;
         1: return jts_pkg::BYTE_RBRACE;
         2: return jts_pkg::BYTE_LBRACKET;
         3: return jts_pkg::BYTE_RBRACKET;
         4: return jts_pkg::BYTE_COLON;
         default: return jts_pkg::BYTE_COMMA;
      endcase
   endfunction

   function automatic logic [7:0] pick_gap_byte();
      case ($urandom_range(0, 6))
         0: return jts_pkg::BYTE_SPACE;
         1: return jts_pkg::BYTE_TAB;
         2: return jts_pkg::BYTE_LF;
         3: return jts_pkg::BYTE_CR;
         4: return jts_pkg::BYTE_BOM_EF;
         5: return jts_pkg::BYTE_BOM_BB;
         default: return jts_pkg::BYTE_BOM_BF;
      endcase
   endfunction

   // one json-like document with random content, mostly closed by end of stream
   task automatic send_document();
      string      word_chars;
      logic [7:0] b;
      word_chars = "0123456789truefalsn.-+eE";
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 4))
            0: send_word(pick_structural(), 1'b0);
            1: begin
               send_word(jts_pkg::BYTE_QUOTE, 1'b0);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     send_word(jts_pkg::BYTE_BACKSLASH, 1'b0);
                     send_word(8'($urandom_range(0, 255)), 1'b0);
                  end else begin
                     b = 8'($urandom_range(0, 255));
                     if (b inside {jts_pkg::BYTE_QUOTE, jts_pkg::BYTE_BACKSLASH})
                        b = 8'h61;
                     send_word(b, 1'b0);
                  end
               end
               send_word(jts_pkg::BYTE_QUOTE, 1'b0);
               // trailing bytes after the closing quote stay in the same token
               if ($urandom_range(0, 3) == 0)
                  send_word(word_chars[$urandom_range(0, word_chars.len() - 1)], 1'b0);
            end
            2: repeat ($urandom_range(1, 5))
                  send_word(word_chars[$urandom_range(0, word_chars.len() - 1)], 1'b0);
            3: repeat ($urandom_range(1, 3))
                  send_word(pick_gap_byte(), 1'b0);
            default: begin
               send_word(jts_pkg::BYTE_BACKSLASH, 1'b0);
               repeat ($urandom_range(0, 4))
                  send_word(word_chars[$urandom_range(0, word_chars.len() - 1)], 1'b0);
               send_word(jts_pkg::BYTE_QUOTE, 1'b0);
            end
         endcase
         case ($urandom_range(0, 2))
            0: send_word(pick_gap_byte(), 1'b0);
            1: send_word(pick_structural(), 1'b0);
            default: ;
         endcase
      end
      if ($urandom_range(0, 7) != 0)
         send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_drained();
      while (words_to_send.size() != 0 || staged || req_valid || tokens_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // byte order mark, escaped quote, bytes after a closing quote, empty tokens
      send_word(jts_pkg::BYTE_BOM_EF, 1'b0);
      send_word(jts_pkg::BYTE_BOM_BB, 1'b0);
      send_word(jts_pkg::BYTE_BOM_BF, 1'b0);
      send_text("{\"a\\\"\"x:[");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(jts_pkg::BYTE_TAB, 1'b0);
      send_word(jts_pkg::BYTE_CR, 1'b0);
      send_word(jts_pkg::BYTE_LF, 1'b0);
      send_word(jts_pkg::BYTE_SPACE, 1'b0);
      send_text("]}");
      // backslash outside a string opens one; end of stream flushes it
      send_text("\\q");
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      // unterminated string with an escape pending
      send_text("\"\\");
      send_word(8'hA5, 1'b1);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent > 700 && !pressure_done) begin
            // sink holds off while the source keeps offering, then the source waits it out
            tx_calm = 1'b1;
            hold_request = 1'b1;
            repeat (8) send_document();
            wait_drained();
            pressure_done = 1'b1;
         end
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 10 && items_sent < ITEM_TARGET; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 20))
                  send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
            end else begin
               send_document();
            end
         end
         while (words_to_send.size() > 4)
            @(negedge clock);
      end
      wait_drained();
      repeat (20) @(negedge clock);

      $display("drove %0d input words (%0d end-of-stream marks) through directed, random",
               items_sent, marks_sent);
      $display("and back-pressure phases; checked %0d token words, %0d mismatches",
               words_checked, error_count);
      if (error_count == 0) begin
         $display("json_token_splitter_tb passed");
      end else begin
         $display("json_token_splitter_tb failed");
      end
      $finish;
   end

endmodule

@@ json_token_splitter.f @@
design/jts_pkg.sv
design/jts_classify.sv
design/jts_queue.sv
design/json_token_splitter.sv
tb/json_token_splitter_tb.sv
